// ===== rtl/lpe_pkg.sv =====
// Package for the LED pattern engine: sizes, codes, payload types and helper functions.
package lpe_pkg;

  localparam int LED_COUNT   = 4;
  localparam int LED_FIELD_W = 4;
  localparam int POS_W       = $clog2(LED_COUNT);

  typedef logic [LED_FIELD_W-1:0] led_mask_t;
  typedef logic [POS_W-1:0]       pos_t;

  localparam led_mask_t ALL_ON      = led_mask_t'((1 << LED_COUNT) - 1);
  localparam led_mask_t CUSTOM_INIT = led_mask_t'(15) & ALL_ON;

  localparam logic [7:0] AUTO_PERIOD_INIT = 8'd50;

  localparam logic [8:0] WAIT_BLINK = 9'd500;
  localparam logic [8:0] WAIT_MOVE  = 9'd200;
  localparam logic [8:0] WAIT_FAST  = 9'd100;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_AUTO     = 3'd1,
    OP_MANUAL   = 3'd2,
    OP_SET_PAT  = 3'd3,
    OP_SET_LED  = 3'd4,
    OP_SET_MASK = 3'd5,
    OP_SET_ALL  = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  localparam logic [2:0] PAT_BLINK    = 3'd0;
  localparam logic [2:0] PAT_SEQUENCE = 3'd1;
  localparam logic [2:0] PAT_CHASE    = 3'd2;
  localparam logic [2:0] PAT_BOUNCE   = 3'd3;
  localparam logic [2:0] PAT_CUSTOM   = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] pattern_sel;
    logic [1:0] led_index;
    logic       led_value;
    logic [3:0] mask_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0] led_drive;
    logic [2:0] active_pattern;
    logic       auto_on;
    logic       bad_request;
    logic [8:0] tick_wait_ms;
  } rsp_t;

  typedef struct packed {
    pos_t pos;
    logic down;
  } pingpong_t;

  // One step of a position that runs up and down between the end LEDs.
  function automatic pingpong_t pingpong_step(pingpong_t cur);
    pingpong_t nxt;
    nxt = cur;
    if (!cur.down) begin
      if (int'(cur.pos) + 1 >= LED_COUNT) begin
        nxt.pos  = pos_t'(LED_COUNT - 2);
        nxt.down = 1'b1;
      end else begin
        nxt.pos = cur.pos + pos_t'(1);
      end
    end else begin
      if (cur.pos == '0) begin
        nxt.pos  = pos_t'(1);
        nxt.down = 1'b0;
      end else begin
        nxt.pos = cur.pos - pos_t'(1);
      end
    end
    return nxt;
  endfunction

  function automatic led_mask_t one_led(pos_t pos);
    return (led_mask_t'(1) << pos) & ALL_ON;
  endfunction

  // LEDs 0 up to and including pos lit.
  function automatic led_mask_t bar_leds(pos_t pos);
    led_mask_t m;
    m = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (i <= int'(pos)) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/lpe_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface lpe_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] pattern_sel;
  logic [1:0] led_index;
  logic       led_value;
  logic [3:0] mask_value;

  modport source (output valid, operation, pattern_sel, led_index, led_value, mask_value,
                  input ready);
  modport sink (input valid, operation, pattern_sel, led_index, led_value, mask_value,
                output ready);
endinterface

interface lpe_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_drive;
  logic [2:0] active_pattern;
  logic       auto_on;
  logic       bad_request;
  logic [8:0] tick_wait_ms;

  modport source (output valid, led_drive, active_pattern, auto_on, bad_request,
                  tick_wait_ms, input ready);
  modport sink (input valid, led_drive, active_pattern, auto_on, bad_request,
                tick_wait_ms, output ready);
endinterface

// ===== rtl/led_pattern_engine_unit.sv =====
// LED pattern engine top level: input register, engine update, result register.
// The accepted command waits in the input register and moves into the result register
// when that slot is free; rsp.valid is driven from the result register.
// Throughput: one command per cycle while the result side does not stall; the state
// update is a single pass of logic between the input register and the result register.
// Reset: synchronous, active high; clears both registers, loads auto_period 50
// and returns the engine to blink pattern in auto mode.
module led_pattern_engine_unit
  import lpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  lpe_cmd_if.sink    cmd,
  lpe_rsp_if.source  rsp
);

  logic in_valid;
  cmd_t in_item;
  logic out_valid;
  rsp_t out_rsp;
  rsp_t step_rsp;
  logic advance;

  // move the held command into the result register when that slot frees up
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_item.operation   <= cmd.operation;
      in_item.pattern_sel <= cmd.pattern_sel;
      in_item.led_index   <= cmd.led_index;
      in_item.led_value   <= cmd.led_value;
      in_item.mask_value  <= cmd.mask_value;
    end
  end

  lpe_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (advance),
    .item        (in_item),
    .result      (step_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= step_rsp;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.led_drive      = out_rsp.led_drive;
  assign rsp.active_pattern = out_rsp.active_pattern;
  assign rsp.auto_on        = out_rsp.auto_on;
  assign rsp.bad_request    = out_rsp.bad_request;
  assign rsp.tick_wait_ms   = out_rsp.tick_wait_ms;

endmodule

// ===== rtl/lpe_engine.sv =====
// Pattern engine state and its single-pass update for one command item.
module lpe_engine
  import lpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       step_en,
  input  cmd_t       item,
  output rsp_t       result
);

  typedef struct packed {
    logic [2:0] pattern;
    logic       auto_flag;
    logic [7:0] tick_count;
    led_mask_t  custom_mask;
    led_mask_t  shown_mask;
    logic       blink_phase;
    pos_t       seq_pos;
    pingpong_t  chase;
    pingpong_t  bounce;
    logic       bounce_phase;
  } engine_state_t;

  engine_state_t st, st_next;
  logic [7:0]    auto_period;
  logic          bad;
  logic [7:0]    tc_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_period <= AUTO_PERIOD_INIT;
    end else if (cfg_wr_en) begin
      auto_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pattern      <= PAT_BLINK;
      st.auto_flag    <= 1'b1;
      st.tick_count   <= '0;
      st.custom_mask  <= CUSTOM_INIT;
      st.shown_mask   <= '0;
      st.blink_phase  <= 1'b0;
      st.seq_pos      <= '0;
      st.chase        <= '0;
      st.bounce       <= '0;
      st.bounce_phase <= 1'b0;
    end else if (step_en) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    bad     = 1'b0;
    tc_inc  = st.tick_count + 8'd1;
    case (op_t'(item.operation))
      OP_TICK: begin
        case (st.pattern)
          PAT_SEQUENCE: begin
            st_next.shown_mask = one_led(st.seq_pos);
            st_next.seq_pos    = (int'(st.seq_pos) == LED_COUNT - 1) ? '0
                                 : st.seq_pos + pos_t'(1);
          end
          PAT_CHASE: begin
            st_next.shown_mask = one_led(st.chase.pos);
            st_next.chase      = pingpong_step(st.chase);
          end
          PAT_BOUNCE: begin
            st_next.shown_mask   = st.bounce_phase ? (bar_leds(st.bounce.pos) & ALL_ON) : '0;
            st_next.bounce_phase = ~st.bounce_phase;
            // bar length moves once per full on/off cycle
            if (st.bounce_phase) st_next.bounce = pingpong_step(st.bounce);
          end
          PAT_CUSTOM: begin
            st_next.shown_mask = st.custom_mask & ALL_ON;
          end
          default: begin
            st_next.blink_phase = ~st.blink_phase;
            st_next.shown_mask  = st.blink_phase ? '0 : ALL_ON;
          end
        endcase
        if (st.auto_flag) begin
          st_next.tick_count = tc_inc;
          if (tc_inc >= auto_period) begin
            st_next.pattern    = {1'b0, st.pattern[1:0] + 2'd1};
            st_next.tick_count = '0;
            st_next.shown_mask = '0;
          end
        end
      end
      OP_AUTO: begin
        st_next.auto_flag  = 1'b1;
        st_next.tick_count = '0;
      end
      OP_MANUAL: begin
        st_next.auto_flag = 1'b0;
      end
      OP_SET_PAT: begin
        if (item.pattern_sel <= PAT_CUSTOM) begin
          st_next.pattern    = item.pattern_sel;
          st_next.tick_count = '0;
          st_next.auto_flag  = 1'b0;
        end else begin
          bad = 1'b1;
        end
      end
      OP_SET_LED: begin
        if (int'(item.led_index) < LED_COUNT) begin
          st_next.shown_mask[item.led_index]  = item.led_value;
          st_next.custom_mask[item.led_index] = item.led_value;
          st_next.pattern   = PAT_CUSTOM;
          st_next.auto_flag = 1'b0;
        end
      end
      OP_SET_MASK: begin
        st_next.custom_mask = item.mask_value & ALL_ON;
        st_next.shown_mask  = item.mask_value & ALL_ON;
        st_next.pattern     = PAT_CUSTOM;
        st_next.auto_flag   = 1'b0;
      end
      OP_SET_ALL: begin
        st_next.custom_mask = item.led_value ? ALL_ON : '0;
        st_next.shown_mask  = item.led_value ? ALL_ON : '0;
        st_next.pattern     = PAT_CUSTOM;
        st_next.auto_flag   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.led_drive      = st_next.shown_mask;
    result.active_pattern = st_next.pattern;
    result.auto_on        = st_next.auto_flag;
    result.bad_request    = bad;
    case (st_next.pattern)
      PAT_SEQUENCE, PAT_CHASE: result.tick_wait_ms = WAIT_MOVE;
      PAT_BOUNCE, PAT_CUSTOM:  result.tick_wait_ms = WAIT_FAST;
      default:                 result.tick_wait_ms = WAIT_BLINK;
    endcase
  end

endmodule

// ===== dv/lpe_checker.sv =====
// Checker for the LED pattern engine: mirrors the engine state and compares every result.
`timescale 1ns / 100ps
module lpe_checker
  import lpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  lpe_cmd_if          cmd,
  lpe_rsp_if          rsp,
  output int unsigned fail_count,
  output int unsigned open_count
);

  typedef struct packed {
    pos_t pos;
    logic down;
  } walker_t;

  logic [7:0] period;
  logic [2:0] pattern;
  logic       auto_en;
  logic [7:0] tick_cnt;
  led_mask_t  custom_leds;
  led_mask_t  lit_leds;
  logic       blink_ph;
  logic       bar_ph;
  pos_t       seq_at;
  walker_t    chase_at;
  walker_t    bar_len;

  rsp_t        expected_rsp[$];
  int unsigned errors = 0;

  task automatic flag_mismatch(string what, logic [8:0] got, logic [8:0] want);
    errors++;
    $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Position bounces between LED 0 and the last LED.
  function automatic walker_t walk_step(walker_t w);
    walker_t n;
    n = w;
    if (!w.down) begin
      if (int'(w.pos) + 1 >= LED_COUNT) begin
        n.pos  = pos_t'(LED_COUNT - 2);
        n.down = 1'b1;
      end else begin
        n.pos = w.pos + pos_t'(1);
      end
    end else if (w.pos == '0) begin
      n.pos  = pos_t'(1);
      n.down = 1'b0;
    end else begin
      n.pos = w.pos - pos_t'(1);
    end
    return n;
  endfunction

  task automatic clear_engine();
    period      = AUTO_PERIOD_INIT;
    pattern     = PAT_BLINK;
    auto_en     = 1'b1;
    tick_cnt    = '0;
    custom_leds = CUSTOM_INIT;
    lit_leds    = '0;
    blink_ph    = 1'b0;
    bar_ph      = 1'b0;
    seq_at      = '0;
    chase_at    = '0;
    bar_len     = '0;
    expected_rsp.delete();
  endtask

  task automatic advance_tick();
    case (pattern)
      PAT_SEQUENCE: begin
        lit_leds = (led_mask_t'(1) << seq_at) & ALL_ON;
        seq_at   = seq_at + pos_t'(1);
      end
      PAT_CHASE: begin
        lit_leds = (led_mask_t'(1) << chase_at.pos) & ALL_ON;
        chase_at = walk_step(chase_at);
      end
      PAT_BOUNCE: begin
        lit_leds = bar_ph ? led_mask_t'((2 << int'(bar_len.pos)) - 1) & ALL_ON : '0;
        bar_ph   = ~bar_ph;
        // bar length moves once per full on/off phase
        if (!bar_ph) bar_len = walk_step(bar_len);
      end
      PAT_CUSTOM: lit_leds = custom_leds & ALL_ON;
      default: begin
        blink_ph = ~blink_ph;
        lit_leds = blink_ph ? ALL_ON : '0;
      end
    endcase
    if (auto_en) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= period) begin
        pattern  = 3'((int'(pattern) + 1) % 4);
        tick_cnt = '0;
        lit_leds = '0;
      end
    end
  endtask

  task automatic predict_leds(input cmd_t c, output rsp_t r);
    logic bad;
    bad = 1'b0;
    case (op_t'(c.operation))
      OP_TICK: advance_tick();
      OP_AUTO: begin
        auto_en  = 1'b1;
        tick_cnt = '0;
      end
      OP_MANUAL: auto_en = 1'b0;
      OP_SET_PAT: begin
        if (c.pattern_sel <= PAT_CUSTOM) begin
          pattern  = c.pattern_sel;
          tick_cnt = '0;
          auto_en  = 1'b0;
        end else begin
          bad = 1'b1;
        end
      end
      OP_SET_LED: begin
        if (int'(c.led_index) < LED_COUNT) begin
          lit_leds[c.led_index]    = c.led_value;
          custom_leds[c.led_index] = c.led_value;
          pattern = PAT_CUSTOM;
          auto_en = 1'b0;
        end
      end
      OP_SET_MASK, OP_SET_ALL: begin
        if (op_t'(c.operation) == OP_SET_MASK) custom_leds = c.mask_value & ALL_ON;
        else custom_leds = c.led_value ? ALL_ON : '0;
        lit_leds = custom_leds;
        pattern  = PAT_CUSTOM;
        auto_en  = 1'b0;
      end
      default: ;
    endcase
    r.led_drive      = lit_leds;
    r.active_pattern = pattern;
    r.auto_on        = auto_en;
    r.bad_request    = bad;
    case (pattern)
      PAT_SEQUENCE, PAT_CHASE: r.tick_wait_ms = WAIT_MOVE;
      PAT_BOUNCE, PAT_CUSTOM:  r.tick_wait_ms = WAIT_FAST;
      default:                 r.tick_wait_ms = WAIT_BLINK;
    endcase
  endtask

  always @(posedge clk) begin
    cmd_t c;
    rsp_t got;
    rsp_t want;
    if (rst) begin
      clear_engine();
    end else begin
      if (cfg_wr_en) period = cfg_wr_data;
      if (cmd.valid && cmd.ready) begin
        c.operation   = cmd.operation;
        c.pattern_sel = cmd.pattern_sel;
        c.led_index   = cmd.led_index;
        c.led_value   = cmd.led_value;
        c.mask_value  = cmd.mask_value;
        predict_leds(c, want);
        expected_rsp.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got.led_drive      = rsp.led_drive;
        got.active_pattern = rsp.active_pattern;
        got.auto_on        = rsp.auto_on;
        got.bad_request    = rsp.bad_request;
        got.tick_wait_ms   = rsp.tick_wait_ms;
        if (expected_rsp.size() == 0) begin
          flag_mismatch("unexpected result transaction", 9'(got.led_drive), '0);
        end else begin
          want = expected_rsp.pop_front();
          if (got.led_drive !== want.led_drive)
            flag_mismatch("led_drive", 9'(got.led_drive), 9'(want.led_drive));
          if (got.active_pattern !== want.active_pattern)
            flag_mismatch("active_pattern", 9'(got.active_pattern), 9'(want.active_pattern));
          if (got.auto_on !== want.auto_on)
            flag_mismatch("auto_on", 9'(got.auto_on), 9'(want.auto_on));
          if (got.bad_request !== want.bad_request)
            flag_mismatch("bad_request", 9'(got.bad_request), 9'(want.bad_request));
          if (got.tick_wait_ms !== want.tick_wait_ms)
            flag_mismatch("tick_wait_ms", got.tick_wait_ms, want.tick_wait_ms);
        end
      end
    end
    fail_count <= errors;
    open_count <= expected_rsp.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the LED pattern engine: clock, reset, command and result traffic, verdict.
`timescale 1ns / 100ps
module tb_top
  import lpe_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  int unsigned fail_count;
  int unsigned open_count;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;

  lpe_cmd_if cmd_ch ();
  lpe_rsp_if rsp_ch ();

  led_pattern_engine_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch)
  );

  lpe_checker mirror (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .open_count  (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze) begin
        squeeze = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(op_t op, logic [2:0] sel, logic [1:0] idx, logic val,
                          logic [3:0] msk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.operation   <= op;
    cmd_ch.pattern_sel <= sel;
    cmd_ch.led_index   <= idx;
    cmd_ch.led_value   <= val;
    cmd_ch.mask_value  <= msk;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Unused fields carry random values.
  task automatic send_op(op_t op);
    send_cmd(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
             1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_op(OP_TICK);
  endtask

  // Wait until every outstanding result transaction has been checked.
  task automatic drain_idle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_period(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic play_chunk();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_op(OP_AUTO);
        send_ticks($urandom_range(1, 40));
      end
      3, 4: begin
        send_cmd(OP_SET_PAT, 3'($urandom_range(0, 4)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        send_ticks($urandom_range(1, 12));
      end
      5, 6: begin
        repeat ($urandom_range(1, 4)) send_op(op_t'($urandom_range(OP_SET_LED, OP_SET_ALL)));
        send_ticks($urandom_range(1, 4));
      end
      7: begin
        send_op(OP_MANUAL);
        send_ticks($urandom_range(1, 6));
      end
      default: repeat ($urandom_range(1, 4)) send_op(op_t'($urandom_range(0, 7)));
    endcase
  endtask

  initial begin : stimulus
    logic [7:0]  periods[6];
    int unsigned quota[6];
    int unsigned goal;

    cmd_ch.valid       <= 1'b0;
    cmd_ch.operation   <= OP_NOP;
    cmd_ch.pattern_sel <= '0;
    cmd_ch.led_index   <= '0;
    cmd_ch.led_value   <= 1'b0;
    cmd_ch.mask_value  <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    rst                <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, every operation, invalid pattern, generator walks.
    send_cmd(OP_TICK, 3'd0, 2'd0, 1'b0, 4'h0);
    send_cmd(OP_NOP, 3'd7, 2'd3, 1'b1, 4'hF);
    send_cmd(OP_SET_PAT, 3'd7, 2'd0, 1'b0, 4'h0);
    send_cmd(OP_SET_PAT, 3'd5, 2'd0, 1'b0, 4'h0);
    send_cmd(OP_SET_PAT, PAT_SEQUENCE, 2'd0, 1'b0, 4'h0);
    send_ticks(2);
    send_cmd(OP_SET_PAT, PAT_CHASE, 2'd0, 1'b0, 4'h0);
    send_ticks(5);
    send_cmd(OP_SET_PAT, PAT_BOUNCE, 2'd0, 1'b0, 4'h0);
    send_ticks(3);
    send_cmd(OP_SET_LED, 3'd0, 2'd3, 1'b0, 4'h0);
    send_cmd(OP_SET_LED, 3'd0, 2'd0, 1'b1, 4'h0);
    send_cmd(OP_SET_MASK, 3'd0, 2'd0, 1'b0, 4'hA);
    send_cmd(OP_SET_MASK, 3'd0, 2'd0, 1'b0, 4'h5);
    send_cmd(OP_SET_ALL, 3'd0, 2'd0, 1'b1, 4'h0);
    send_cmd(OP_SET_ALL, 3'd0, 2'd0, 1'b0, 4'h0);
    send_cmd(OP_SET_PAT, PAT_CUSTOM, 2'd0, 1'b0, 4'h0);
    send_ticks(1);
    send_cmd(OP_MANUAL, 3'd0, 2'd0, 1'b0, 4'h0);
    send_cmd(OP_AUTO, 3'd0, 2'd0, 1'b0, 4'h0);
    send_ticks(1);

    // Zero period: every auto tick moves to the next pattern.
    drain_idle();
    set_period(8'd0);
    send_cmd(OP_AUTO, 3'd0, 2'd0, 1'b0, 4'h0);
    send_ticks(3);

    periods = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 9)), 8'($urandom_range(10, 254)),
                AUTO_PERIOD_INIT};
    quota   = '{170, 140, 300, 220, 150, 150};
    for (int ph = 0; ph < 6; ph++) begin
      drain_idle();
      set_period(periods[ph]);
      calm = (ph == 5);
      if (ph == 3) squeeze = 1'b1;
      goal = sent + quota[ph];
      // long auto run so the widest period still wraps
      if (periods[ph] == 8'd255) begin
        send_op(OP_AUTO);
        send_ticks(260);
      end
      while (sent < goal) play_chunk();
    end

    drain_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d commands across auto periods 1, 0, 255, %0d, %0d and %0d.",
             sent, periods[3], periods[4], periods[5]);
    $display("Traffic mixed all operations, bad pattern requests, random gaps and stalls, "
             , "and one long result hold-off.");
    if (fail_count == 0 && open_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
